// ----- src/fsbc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsbc_pkg
// Shared types and constants for the frustum sphere/box cull block.
// ----------------------------------------------------------------------------
package fsbc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PLANES_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int COORD_W     = 32;
    localparam int COUNT_W     = 7;
    localparam int PLANE_IDX_W = 6;
    localparam int CORNER_W    = 3;
    localparam int SUM_W       = 64;
    localparam int ROW_W       = 4 * COORD_W;

    localparam logic [COUNT_W-1:0] PLANE_COUNT_RST = COUNT_W'(6);

    // Command codes carried in tuser
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SPHERE = 2'd1;
    localparam logic [1:0] CMD_BOX    = 2'd2;

    // Last corner of a box
    localparam logic [CORNER_W-1:0] CORNER_LAST = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                   start;      // latch a new test item
        logic                   empty;      // no planes in use: visible
        logic                   box;        // item is a box test
        logic                   load_we;    // write one plane row
        logic                   issue;      // send one plane/corner pair
        logic [PLANE_IDX_W-1:0] plane;
        logic [CORNER_W-1:0]    corner;
        logic                   last_plane; // last plane of this corner
        logic                   last_item;  // last pair of the item
        logic                   out_load;   // move result to output
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic done;                         // final pair has been scored
    } dp_status_t;

    // Clamp a 33-bit sum to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W:0] v
    );
        logic signed [COORD_W-1:0] r;
        begin
            if (v[COORD_W] != v[COORD_W-1])
            begin
                r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                               : {1'b0, {(COORD_W-1){1'b1}}};
            end
            else
            begin
                r = v[COORD_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ----- src/fsbc_ram.sv -----
// ----------------------------------------------------------------------------
// fsbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fsbc_datapath.sv -----
// ----------------------------------------------------------------------------
// fsbc_datapath
// Plane table, corner generation, dot product pipeline and result register.
// ----------------------------------------------------------------------------
module fsbc_datapath
    import fsbc_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    input  logic [PLANE_IDX_W-1:0]    plane_index,
    input  logic signed [COORD_W-1:0] first_x,
    input  logic signed [COORD_W-1:0] first_y,
    input  logic signed [COORD_W-1:0] first_z,
    input  logic signed [COORD_W-1:0] first_w,
    input  logic signed [COORD_W-1:0] second_x,
    input  logic signed [COORD_W-1:0] second_y,
    input  logic signed [COORD_W-1:0] second_z,
    output dp_status_t                status,
    output logic                      visible
);

    localparam int IDX_W = $clog2(MAX_PLANES);

    // Test item registers
    logic signed [COORD_W-1:0] fx_reg, fy_reg, fz_reg, fw_reg;
    logic signed [COORD_W-1:0] hx_reg, hy_reg, hz_reg;

    // Row valid bits: a row never loaded reads as zero
    logic [MAX_PLANES-1:0] row_valid_reg;

    // Stage 1: corner and limit, RAM read in flight
    logic                      s1_valid_reg;
    logic                      s1_row_ok_reg;
    logic                      s1_last_plane_reg;
    logic                      s1_last_item_reg;
    logic signed [COORD_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [SUM_W-1:0]   s1_limit_reg;

    // Stage 2: products
    logic                      s2_valid_reg;
    logic                      s2_last_plane_reg;
    logic                      s2_last_item_reg;
    logic signed [SUM_W-1:0]   s2_pa_reg, s2_pb_reg, s2_pc_reg;
    logic signed [COORD_W-1:0] s2_d_reg;
    logic signed [SUM_W-1:0]   s2_limit_reg;

    // Accumulators and output data
    logic corner_ok_reg, corner_ok_next;
    logic vis_reg, vis_next;
    logic out_reg;

    logic [ROW_W-1:0]          ram_rdata;
    logic [ROW_W-1:0]          row;
    logic                      wr_en;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic signed [SUM_W-1:0]   dot;
    logic                      pass;

    // Plane table
    assign wr_en = cmd.load_we;

    fsbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_PLANES)
    ) u_planes (
        .clk   (clk),
        .we    (wr_en),
        .waddr (plane_index[IDX_W-1:0]),
        .wdata ({first_w, first_z, first_y, first_x}),
        .raddr (cmd.plane[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[plane_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    // Latch the test item
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            fx_reg <= first_x;
            fy_reg <= first_y;
            fz_reg <= first_z;
            fw_reg <= first_w;
            hx_reg <= second_x;
            hy_reg <= second_y;
            hz_reg <= second_z;
        end
    end

    // Corner select: bit set means minus the half size
    always_comb
    begin
        cx = fx_reg;
        cy = fy_reg;
        cz = fz_reg;
        if (cmd.box)
        begin
            cx = sat_coord(cmd.corner[0] ? ({fx_reg[COORD_W-1], fx_reg} - {hx_reg[COORD_W-1], hx_reg})
                                         : ({fx_reg[COORD_W-1], fx_reg} + {hx_reg[COORD_W-1], hx_reg}));
            cy = sat_coord(cmd.corner[1] ? ({fy_reg[COORD_W-1], fy_reg} - {hy_reg[COORD_W-1], hy_reg})
                                         : ({fy_reg[COORD_W-1], fy_reg} + {hy_reg[COORD_W-1], hy_reg}));
            cz = sat_coord(cmd.corner[2] ? ({fz_reg[COORD_W-1], fz_reg} - {hz_reg[COORD_W-1], hz_reg})
                                         : ({fz_reg[COORD_W-1], fz_reg} + {hz_reg[COORD_W-1], hz_reg}));
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        s1_row_ok_reg     <= row_valid_reg[cmd.plane[IDX_W-1:0]];
        s1_last_plane_reg <= cmd.last_plane;
        s1_last_item_reg  <= cmd.last_item;
        s1_x_reg          <= cx;
        s1_y_reg          <= cy;
        s1_z_reg          <= cz;
        s1_limit_reg      <= cmd.box ? '0 : -SUM_W'(fw_reg);
    end

    // Stage 2: three products
    assign row = s1_row_ok_reg ? ram_rdata : '0;

    always_ff @(posedge clk)
    begin
        s2_pa_reg         <= SUM_W'($signed(row[COORD_W-1:0]) * s1_x_reg);
        s2_pb_reg         <= SUM_W'($signed(row[2*COORD_W-1:COORD_W]) * s1_y_reg);
        s2_pc_reg         <= SUM_W'($signed(row[3*COORD_W-1:2*COORD_W]) * s1_z_reg);
        s2_d_reg          <= row[4*COORD_W-1:3*COORD_W];
        s2_limit_reg      <= s1_limit_reg;
        s2_last_plane_reg <= s1_last_plane_reg;
        s2_last_item_reg  <= s1_last_item_reg;
    end

    // Stage 3: floor-scaled sum and compare
    assign dot  = (s2_pa_reg >>> FRAC_BITS) + (s2_pb_reg >>> FRAC_BITS)
                + (s2_pc_reg >>> FRAC_BITS) + SUM_W'(s2_d_reg);
    assign pass = (dot >= s2_limit_reg);

    always_comb
    begin
        corner_ok_next = corner_ok_reg;
        vis_next       = vis_reg;
        if (cmd.start)
        begin
            corner_ok_next = 1'b1;
            vis_next       = cmd.empty;
        end
        else if (s2_valid_reg)
        begin
            if (s2_last_plane_reg)
            begin
                vis_next       = vis_reg | (corner_ok_reg & pass);
                corner_ok_next = 1'b1;
            end
            else
            begin
                corner_ok_next = corner_ok_reg & pass;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        corner_ok_reg <= corner_ok_next;
        vis_reg       <= vis_next;
        if (cmd.out_load)
        begin
            out_reg <= vis_reg;
        end
    end

    assign status.done = s2_valid_reg & s2_last_item_reg;
    assign visible     = out_reg;

endmodule

// ----- src/fsbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsbc_ctrl
// Sequencer: input handshake, plane/corner walk, output valid, plane count.
// ----------------------------------------------------------------------------
module fsbc_ctrl
    import fsbc_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             command,
    input  logic [PLANE_IDX_W-1:0] plane_index,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_we,
    input  logic [COUNT_W-1:0]     cfg_wdata,
    input  dp_status_t             status,
    output ctrl_cmd_t              cmd
);

    localparam int                 IDX_W     = $clog2(MAX_PLANES);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PLANES);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    plane_reg, plane_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;
    logic                box_reg, box_next;
    logic                m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]  count_reg;

    logic               accept;
    logic               is_test;
    logic [COUNT_W-1:0] used;
    logic               last_plane;
    logic               last_item;
    logic               out_free;

    // Plane count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= PLANE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    assign used       = (count_reg > MAX_COUNT) ? MAX_COUNT : count_reg;
    assign accept     = s_tvalid & s_tready;
    assign is_test    = (command == CMD_SPHERE) || (command == CMD_BOX);
    assign last_plane = (COUNT_W'(plane_reg) + COUNT_W'(1)) == used;
    assign last_item  = last_plane && (!box_reg || corner_reg == CORNER_LAST);
    assign out_free   = !m_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_test)
                begin
                    state_next = (used == '0) ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (last_item)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and counter updates
    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.box        = box_reg;
        cmd.plane      = PLANE_IDX_W'(plane_reg);
        cmd.corner     = corner_reg;
        cmd.last_plane = last_plane;
        cmd.last_item  = last_item;
        cmd.empty      = (used == '0);
        plane_next     = plane_reg;
        corner_next    = corner_reg;
        box_next       = box_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_we = accept && (command == CMD_LOAD)
                              && (COUNT_W'(plane_index) < MAX_COUNT);
                cmd.start   = accept && is_test;
                if (accept && is_test)
                begin
                    box_next    = (command == CMD_BOX);
                    plane_next  = '0;
                    corner_next = '0;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (last_plane)
                begin
                    plane_next  = '0;
                    corner_next = corner_reg + CORNER_W'(1);
                end
                else
                begin
                    plane_next = plane_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                cmd.issue = 1'b0;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.issue = 1'b0;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            plane_reg   <= '0;
            corner_reg  <= '0;
            box_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            plane_reg   <= plane_next;
            corner_reg  <= corner_next;
            box_reg     <= box_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ----- src/frustum_sphere_box_cull.sv -----
// ----------------------------------------------------------------------------
// frustum_sphere_box_cull
// Frustum culling of spheres, points and axis-aligned boxes against a
// loadable table of planes in signed Q16.16.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer carries
//  s_*       in         command (tuser), plane index and seven Q16.16 words
//  m_*       out        visible flag
//  cfg_*     in         plane_count register write
//
//  With n planes in use (plane_count, capped at MAX_PLANES), a sphere or
//  point test scores n plane rows and a box test all eight corners
//  against n rows each: one plane row is read and scored per cycle through
//  a three-stage read/multiply/sum pipeline fed from the single plane RAM.
//  Reset clears the row valid bits, so every plane reads as zero until
//  loaded, and sets plane_count to 6. A result waiting on m_tready does
//  not block the next item; only the next test's result stalls behind it.
// ----------------------------------------------------------------------------
module frustum_sphere_box_cull
    import fsbc_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [231:0]       s_tdata,   // plane_index, first_x, first_y, first_z,
                                          // first_w, second_x, second_y, second_z, pad
    input  logic [1:0]         s_tuser,   // command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // visible, pad
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       visible;

    logic [PLANE_IDX_W-1:0]    plane_index;
    logic signed [COORD_W-1:0] first_x, first_y, first_z, first_w;
    logic signed [COORD_W-1:0] second_x, second_y, second_z;

    // Unpack the input transfer
    assign plane_index = s_tdata[5:0];
    assign first_x     = s_tdata[37:6];
    assign first_y     = s_tdata[69:38];
    assign first_z     = s_tdata[101:70];
    assign first_w     = s_tdata[133:102];
    assign second_x    = s_tdata[165:134];
    assign second_y    = s_tdata[197:166];
    assign second_z    = s_tdata[229:198];

    fsbc_ctrl #(
        .MAX_PLANES (MAX_PLANES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .command     (s_tuser),
        .plane_index (plane_index),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .status      (status),
        .cmd         (cmd)
    );

    fsbc_datapath #(
        .MAX_PLANES (MAX_PLANES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .plane_index (plane_index),
        .first_x     (first_x),
        .first_y     (first_y),
        .first_z     (first_z),
        .first_w     (first_w),
        .second_x    (second_x),
        .second_y    (second_y),
        .second_z    (second_z),
        .status      (status),
        .visible     (visible)
    );

    assign m_tdata = {7'b0, visible};

endmodule
